[hdl/half_step_stepper_sequencer_unit_macros.svh]
// assertion macros for the half-step stepper sequencer
// used by the top level only, no other dependencies
`ifndef HALF_STEP_STEPPER_SEQUENCER_UNIT_MACROS_SVH
`define HALF_STEP_STEPPER_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check a property while out of reset
`define HSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define HSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HSS_ASSERT(lbl, clk, rstn, prop, msg)
`define HSS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[hdl/hss_pkg.sv]
// shared types, codes and the coil pattern table for the stepper sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

    localparam int STEPS_W = 18;

    localparam logic signed [STEPS_W-1:0] STEPS_MAX = 18'sh1FFFF;
    localparam logic signed [STEPS_W-1:0] STEPS_MIN = 18'sh20000;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_REL  = 2'd1,
        REQ_ABS  = 2'd2
    } req_kind_t;

    // configuration register indexes
    localparam logic CFG_STEPS_PER_REV = 1'b0;
    localparam logic CFG_STEP_DELAY    = 1'b1;

    // fixed-width part of the motor state
    typedef struct packed {
        logic [2:0]                phase;
        logic signed [STEPS_W-1:0] steps_left;
        logic [3:0]                coil_levels;
    } core_state_t;

    // one result beat
    typedef struct packed {
        logic                      stepped;
        logic                      move_done;
        logic signed [STEPS_W-1:0] remaining_steps;
        logic [15:0]               position_now;
        logic [3:0]                coil_drive;
    } result_t;

    // half-step phase to coil levels, first coil in bit 3
    function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
        logic [3:0] levels;
        case (phase)
            3'd0:    levels = 4'b1001;
            3'd1:    levels = 4'b0001;
            3'd2:    levels = 4'b0011;
            3'd3:    levels = 4'b0010;
            3'd4:    levels = 4'b0110;
            3'd5:    levels = 4'b0100;
            3'd6:    levels = 4'b1100;
            default: levels = 4'b1000;
        endcase
        return levels;
    endfunction

endpackage

`default_nettype wire

[hdl/hss_step_core.sv]
// next-state and result logic for one request of the stepper sequencer
// depends on hss_pkg
`timescale 1ns / 1ps
`default_nettype none

module hss_step_core
    import hss_pkg::*;
#(
    parameter int POS_WIDTH   = 16,
    parameter int TIMER_WIDTH = 20
) (
    input  core_state_t                  state_i,
    input  logic [POS_WIDTH-1:0]         position_i,
    input  logic [TIMER_WIDTH-1:0]       elapsed_i,
    input  logic [15:0]                  steps_per_rev_i,
    input  logic [19:0]                  step_delay_i,
    input  logic [1:0]                   req_type_i,
    input  logic signed [15:0]           move_steps_i,
    input  logic [15:0]                  target_position_i,
    output core_state_t                  state_next,
    output logic [POS_WIDTH-1:0]         position_next,
    output logic [TIMER_WIDTH-1:0]       elapsed_next,
    output result_t                      result_o
);

    localparam int PW_MAX = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam int MW     = PW_MAX + 1;
    localparam int AW     = PW_MAX + 3;
    localparam int CW     = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;

    localparam logic signed [AW-1:0] CLAMP_HI =
        {{(AW-STEPS_W){STEPS_MAX[STEPS_W-1]}}, STEPS_MAX};
    localparam logic signed [AW-1:0] CLAMP_LO =
        {{(AW-STEPS_W){STEPS_MIN[STEPS_W-1]}}, STEPS_MIN};

    // wrap modulus: revolution size, or the full position range when zero or out of reach
    logic [MW-1:0] pos_lim;
    logic [MW-1:0] spr_ext;
    logic [MW-1:0] modulus;
    logic [MW-1:0] modulus_m1;
    logic [MW-1:0] pos_ext;
    logic [MW-1:0] pos_inc;
    logic [POS_WIDTH-1:0] cw_pos;
    logic [POS_WIDTH-1:0] ccw_pos;

    assign pos_lim    = MW'(1) << POS_WIDTH;
    assign spr_ext    = MW'(steps_per_rev_i);
    assign modulus    = (steps_per_rev_i == 16'd0 || spr_ext > pos_lim) ? pos_lim : spr_ext;
    assign modulus_m1 = modulus - MW'(1);
    assign pos_ext    = MW'(position_i);
    assign pos_inc    = pos_ext + MW'(1);

    // position one step either way
    assign cw_pos  = (pos_inc >= modulus) ? '0 : pos_inc[POS_WIDTH-1:0];
    assign ccw_pos = (position_i == '0 || pos_ext >= modulus) ?
                     modulus_m1[POS_WIDTH-1:0] : position_i - POS_WIDTH'(1);

    // step outcome
    logic                      step_cw;
    logic [2:0]                step_phase;
    logic signed [STEPS_W-1:0] step_steps;
    logic [POS_WIDTH-1:0]      step_pos;
    logic [3:0]                step_coil;

    assign step_cw    = (state_i.steps_left > 0);
    assign step_phase = step_cw ? state_i.phase - 3'd1 : state_i.phase + 3'd1;
    assign step_steps = step_cw ? state_i.steps_left - STEPS_W'(1)
                                : state_i.steps_left + STEPS_W'(1);
    assign step_pos   = step_cw ? cw_pos : ccw_pos;
    assign step_coil  = (step_steps == '0) ? 4'b0000 : coil_pattern(step_phase);

    // saturating elapsed counter and clamped delay
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [CW-1:0]          elapsed_ext;
    logic [CW-1:0]          delay_ext;
    logic [CW-1:0]          tmax_ext;
    logic [CW-1:0]          delay_clamped;
    logic                   step_due;

    assign elapsed_inc   = (&elapsed_i) ? elapsed_i : elapsed_i + TIMER_WIDTH'(1);
    assign elapsed_ext   = CW'(elapsed_inc);
    assign delay_ext     = CW'(step_delay_i);
    assign tmax_ext      = CW'({TIMER_WIDTH{1'b1}});
    assign delay_clamped = (delay_ext > tmax_ext) ? tmax_ext : delay_ext;
    assign step_due      = (state_i.steps_left != '0) && (elapsed_ext >= delay_clamped);

    // shortest wrapped route to an absolute target, then saturate
    logic signed [AW-1:0]      diff;
    logic signed [AW-1:0]      rev_s;
    logic signed [AW-1:0]      half_s;
    logic signed [AW-1:0]      route;
    logic signed [STEPS_W-1:0] abs_steps;

    assign diff   = AW'($signed({1'b0, target_position_i})) - AW'($signed({1'b0, position_i}));
    assign rev_s  = AW'($signed({1'b0, steps_per_rev_i}));
    assign half_s = AW'($signed({2'b00, steps_per_rev_i[15:1]}));
    assign route  = (diff > half_s)  ? diff - rev_s :
                    (diff < -half_s) ? diff + rev_s : diff;
    assign abs_steps = (route > CLAMP_HI) ? STEPS_MAX :
                       (route < CLAMP_LO) ? STEPS_MIN : route[STEPS_W-1:0];

    // request decode
    logic stepped;

    always_comb begin
        state_next    = state_i;
        position_next = position_i;
        elapsed_next  = elapsed_i;
        stepped       = 1'b0;
        case (req_kind_t'(req_type_i))
            REQ_TICK: begin
                elapsed_next = elapsed_inc;
                if (step_due) begin
                    state_next.phase       = step_phase;
                    state_next.steps_left  = step_steps;
                    state_next.coil_levels = step_coil;
                    position_next          = step_pos;
                    elapsed_next           = '0;
                    stepped                = 1'b1;
                end
            end
            REQ_REL: begin
                state_next.coil_levels = coil_pattern(state_i.phase);
                state_next.steps_left  = STEPS_W'(move_steps_i);
            end
            REQ_ABS: begin
                state_next.coil_levels = coil_pattern(state_i.phase);
                state_next.steps_left  = abs_steps;
            end
            default: ;
        endcase
    end

    // result beat
    always_comb begin
        result_o.coil_drive      = state_next.coil_levels;
        result_o.position_now    = 16'(position_next);
        result_o.remaining_steps = state_next.steps_left;
        result_o.move_done       = (state_next.steps_left == '0);
        result_o.stepped         = stepped;
    end

endmodule

`default_nettype wire

[hdl/half_step_stepper_sequencer_unit.sv]
// top level of the half-step stepper sequencer: stream ports, config and state registers
// depends on hss_pkg, hss_step_core and half_step_stepper_sequencer_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "half_step_stepper_sequencer_unit_macros.svh"

// Half-step driver for a four-coil unipolar stepper. Each input beat is a
// one-microsecond tick, a relative move or a move to an absolute position; each
// produces exactly one result beat with the coil levels, position, steps still to
// go and status flags. One beat is accepted per clock when the result side keeps
// up; a result beat is presented on m_tdata once its request beat has passed the
// input register and then the state update that writes the result register. The
// motor state is updated in the same cycle as the result register, so a following
// beat sees it at once.
// Configuration registers are written through cfg_wr_en / cfg_addr / cfg_wdata
// and should only change while no beat is in flight.

module half_step_stepper_sequencer_unit
    import hss_pkg::*;
#(
    parameter int POS_WIDTH   = 16,
    parameter int TIMER_WIDTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [19:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // move_steps[15:0], target_position[31:16]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // coil_drive[3:0], position_now[19:4],
                                   // remaining_steps[37:20], move_done[38], stepped[39]
);

    // configuration registers
    logic [15:0] steps_per_rev_reg;
    logic [19:0] step_delay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_per_rev_reg <= 16'd4096;
            step_delay_reg    <= 20'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STEPS_PER_REV: steps_per_rev_reg <= cfg_wdata[15:0];
                CFG_STEP_DELAY:    step_delay_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic in_load;
    logic out_load;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;
    assign out_load = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input register
    logic [1:0]         req_type_reg;
    logic signed [15:0] move_steps_reg;
    logic [15:0]        target_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            req_type_reg   <= s_tuser;
            move_steps_reg <= s_tdata[15:0];
            target_reg     <= s_tdata[31:16];
        end
    end

    // motor state
    core_state_t            state_reg;
    core_state_t            state_next;
    logic [POS_WIDTH-1:0]   position_reg;
    logic [POS_WIDTH-1:0]   position_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;
    result_t                result_next;
    result_t                result_reg;

    hss_step_core #(
        .POS_WIDTH   (POS_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .state_i           (state_reg),
        .position_i        (position_reg),
        .elapsed_i         (elapsed_reg),
        .steps_per_rev_i   (steps_per_rev_reg),
        .step_delay_i      (step_delay_reg),
        .req_type_i        (req_type_reg),
        .move_steps_i      (move_steps_reg),
        .target_position_i (target_reg),
        .state_next        (state_next),
        .position_next     (position_next),
        .elapsed_next      (elapsed_next),
        .result_o          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            position_reg <= '0;
            elapsed_reg  <= '1;
        end else if (out_load) begin
            state_reg    <= state_next;
            position_reg <= position_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // checks
    `HSS_ASSERT(a_step_clears_timer, aclk, aresetn, out_load && result_next.stepped |=> elapsed_reg == '0, "step did not clear the elapsed counter")
    `HSS_ASSERT(a_phase_only_on_step, aclk, aresetn, out_load && !result_next.stepped |=> $stable(state_reg.phase), "phase moved without a step")
    `HSS_ASSERT(a_finish_coils_off, aclk, aresetn, m_tvalid && m_tdata[39] && m_tdata[38] |-> m_tdata[3:0] == 4'b0000, "coils left on after the last step")
    `HSS_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid && !in_valid_reg, "pipeline not empty after reset")

endmodule

`default_nettype wire

[tb/half_step_stepper_sequencer_unit_tb.sv]
// self-checking bench for the half-step stepper sequencer: directed rows, then random move/tick runs
// depends on hss_pkg and half_step_stepper_sequencer_unit; checked against row values or a motor model
`timescale 1ns / 1ps

module half_step_stepper_sequencer_unit_tb;
    import hss_pkg::*;

    localparam int          TIMER_TOP  = 20'hFFFFF;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    // half-step coil sequence, phase 0 in the lowest nibble, first coil in bit 3
    localparam logic [31:0] COIL_SEQ   = {4'b1000, 4'b1100, 4'b0100, 4'b0110,
                                          4'b0010, 4'b0011, 4'b0001, 4'b1001};

    typedef struct {
        bit      known;
        result_t value;
    } typed_exp_t;

    typedef struct {
        bit          is_cfg;
        logic        cfg_reg;
        logic [19:0] cfg_val;
        logic [1:0]  kind;
        logic [15:0] move;
        logic [15:0] target;
        bit          known;
        result_t     want;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // move_steps[15:0], target_position[31:16]
    logic [1:0]  s_tuser   = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // coil_drive, position_now, remaining_steps, move_done, stepped

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;

    // motor model: configuration and state
    int         mtr_rev     = 4096;
    int         mtr_delay   = 1000;
    logic [2:0] mtr_phase   = 3'd0;
    int         mtr_pos     = 0;
    int         mtr_left    = 0;
    int         mtr_elapsed = TIMER_TOP;
    logic [3:0] mtr_coils   = 4'b0000;

    result_t    pending_results[$];
    typed_exp_t typed_q[$];
    dir_row_t   dir_rows[$];

    half_step_stepper_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // random back-pressure on the result side
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // advance the motor model by one request beat and form its result
    task automatic predict_stepper(input logic [1:0] kind, input logic [15:0] mv,
                                   input logic [15:0] tgt, output result_t r);
        int m;
        int diff;
        int mag;
        bit st;
        st = 1'b0;
        m  = (mtr_rev == 0) ? 65536 : mtr_rev;
        case (kind)
            REQ_TICK: begin
                if (mtr_elapsed < TIMER_TOP) mtr_elapsed++;
                if (mtr_left != 0 && mtr_elapsed >= mtr_delay) begin
                    if (mtr_left > 0) begin
                        // clockwise: phase down, position up
                        mtr_phase = mtr_phase - 3'd1;
                        mtr_pos   = (mtr_pos + 1 >= m) ? 0 : mtr_pos + 1;
                        mtr_left--;
                    end else begin
                        mtr_phase = mtr_phase + 3'd1;
                        mtr_pos   = (mtr_pos == 0 || mtr_pos >= m) ? m - 1 : mtr_pos - 1;
                        mtr_left++;
                    end
                    mtr_coils   = (mtr_left == 0) ? 4'b0000 : COIL_SEQ[{mtr_phase, 2'b00} +: 4];
                    mtr_elapsed = 0;
                    st          = 1'b1;
                end
            end
            REQ_REL: begin
                mtr_coils = COIL_SEQ[{mtr_phase, 2'b00} +: 4];
                mtr_left  = int'($signed(mv));
            end
            REQ_ABS: begin
                // shortest wrapped route, corrected by one revolution
                mtr_coils = COIL_SEQ[{mtr_phase, 2'b00} +: 4];
                diff      = int'(tgt) - mtr_pos;
                mag       = (diff < 0) ? -diff : diff;
                if (mag > mtr_rev / 2) diff = (diff > 0) ? diff - mtr_rev : diff + mtr_rev;
                if (diff > 131071) diff = 131071;
                if (diff < -131072) diff = -131072;
                mtr_left  = diff;
            end
            default: ;
        endcase
        r.coil_drive      = mtr_coils;
        r.position_now    = mtr_pos[15:0];
        r.remaining_steps = mtr_left[17:0];
        r.move_done       = (mtr_left == 0);
        r.stepped         = st;
    endtask

    // predict on every accepted request beat, check every accepted result beat
    always @(posedge aclk) begin
        result_t    calc;
        result_t    got;
        result_t    want;
        typed_exp_t tx;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_stepper(s_tuser, s_tdata[15:0], s_tdata[31:16], calc);
                tx.known = 1'b0;
                if (typed_q.size() != 0) tx = typed_q.pop_front();
                pending_results.push_back(tx.known ? tx.value : calc);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", got, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.coil_drive !== want.coil_drive)
                        report_mismatch("coil_drive", got.coil_drive, want.coil_drive);
                    if (got.position_now !== want.position_now)
                        report_mismatch("position_now", got.position_now, want.position_now);
                    if (got.remaining_steps !== want.remaining_steps)
                        report_mismatch("remaining_steps", $signed(got.remaining_steps),
                                        $signed(want.remaining_steps));
                    if (got.move_done !== want.move_done)
                        report_mismatch("move_done", got.move_done, want.move_done);
                    if (got.stepped !== want.stepped)
                        report_mismatch("stepped", got.stepped, want.stepped);
                end
            end
        end
    end

    function automatic result_t mk_res(input logic [3:0] coil, input int pos, input int rem,
                                       input bit done, input bit st);
        result_t r;
        r.coil_drive      = coil;
        r.position_now    = pos[15:0];
        r.remaining_steps = rem[17:0];
        r.move_done       = done;
        r.stepped         = st;
        return r;
    endfunction

    // stop sending and wait until every outstanding result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 || typed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only ever issued with the pipeline empty
    task automatic write_reg(input logic idx, input int val);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[19:0];
        @(posedge aclk);
        if (idx == CFG_STEPS_PER_REV) mtr_rev = val & 16'hFFFF;
        else mtr_delay = val & 20'hFFFFF;
        cfg_wr_en <= 1'b0;
    endtask

    // offer one request beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [1:0] kind, input logic [15:0] mv,
                             input logic [15:0] tgt, input bit known, input result_t want);
        typed_exp_t tx;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        tx.known = known;
        tx.value = want;
        typed_q.push_back(tx);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {tgt, mv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic add_cfg(input logic idx, input int val);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_reg = idx;
        row.cfg_val = val[19:0];
        dir_rows.push_back(row);
    endtask

    task automatic add_beat(input logic [1:0] kind, input logic [15:0] mv,
                            input logic [15:0] tgt, input bit known, input result_t want);
        dir_row_t row;
        row = '{default: '0};
        row.kind   = kind;
        row.move   = mv;
        row.target = tgt;
        row.known  = known;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    // random phase: mostly a move followed by a capped run of ticks to walk it, some noise
    task automatic run_phase(input int rev, input int delay, input int idle_pct,
                             input int stall_pct, input int n_beats);
        int          sent;
        int          pick;
        int          span;
        int          ticks;
        int          d;
        int          m;
        logic [15:0] mv;
        logic [15:0] tgt;
        logic [15:0] aim;
        write_reg(CFG_STEPS_PER_REV, rev);
        write_reg(CFG_STEP_DELAY, delay);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        aim  = '0;
        while (sent < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 3) wait_results_drained();
            if (pick < 10) begin
                send_beat(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 1'b0, '0);
                sent++;
            end else begin
                m = (rev == 0) ? 65536 : rev;
                if (pick < 60) begin
                    span = $urandom_range(20);
                    if ($urandom_range(9) == 0) mv = 16'($urandom);
                    else mv = $urandom_range(1) ? 16'(span) : 16'(-span);
                    send_beat(REQ_REL, mv, 16'($urandom), 1'b0, '0);
                end else begin
                    if ($urandom_range(9) == 0) tgt = 16'($urandom);
                    else tgt = 16'((int'(aim) + $urandom_range(40) + m - 20) % m);
                    aim  = tgt;
                    span = 20;
                    send_beat(REQ_ABS, 16'($urandom), tgt, 1'b0, '0);
                end
                d     = (delay > 6) ? 6 : delay;
                ticks = span * (d + 1) + $urandom_range(4);
                if (ticks > 60) ticks = 60;
                if ($urandom_range(4) == 0) ticks = $urandom_range(ticks);
                repeat (ticks) send_beat(REQ_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
                sent += 1 + ticks;
            end
        end
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        dir_row_t row;

        // directed rows, reset configuration first
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b0000, 0, 0, 1, 0));
        add_beat(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 1, mk_res(4'b0000, 0, 0, 1, 0));
        add_beat(REQ_REL,    16'h0000, 16'hFFFF, 1, mk_res(4'b1001, 0, 0, 1, 0));
        add_beat(REQ_TICK,   16'hFFFF, 16'hFFFF, 1, mk_res(4'b1001, 0, 0, 1, 0));
        add_beat(REQ_REL,    16'd2,    16'h0000, 1, mk_res(4'b1001, 0, 2, 0, 0));
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b1000, 1, 1, 0, 1));
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b1000, 1, 1, 0, 0));
        add_beat(REQ_REL,    16'h8000, 16'h0000, 1, mk_res(4'b1000, 1, -32768, 0, 0));
        add_beat(REQ_REL,    16'h7FFF, 16'h0000, 1, mk_res(4'b1000, 1, 32767, 0, 0));
        add_beat(REQ_ABS,    16'hFFFF, 16'd0,    1, mk_res(4'b1000, 1, -1, 0, 0));
        add_beat(REQ_ABS,    16'h0000, 16'hFFFF, 0, '0);
        add_beat(REQ_ABS,    16'h0000, 16'd2049, 1, mk_res(4'b1000, 1, 2048, 0, 0));
        add_beat(REQ_ABS,    16'h0000, 16'd2050, 1, mk_res(4'b1000, 1, -2047, 0, 0));
        add_beat(REQ_ABS,    16'h0000, 16'd1,    1, mk_res(4'b1000, 1, 0, 1, 0));
        add_beat(REQ_REL,    16'hFFFF, 16'h0000, 1, mk_res(4'b1000, 1, -1, 0, 0));
        // zero delay: counter-clockwise steps, wrap below zero
        add_cfg(CFG_STEP_DELAY, 0);
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b0000, 0, 0, 1, 1));
        add_beat(REQ_REL,    16'hFFFF, 16'h0000, 1, mk_res(4'b1001, 0, -1, 0, 0));
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b0000, 4095, 0, 1, 1));
        // one-step revolution with the position left outside it
        add_cfg(CFG_STEPS_PER_REV, 1);
        add_beat(REQ_REL,    16'd1,    16'h0000, 1, mk_res(4'b0001, 4095, 1, 0, 0));
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b0000, 0, 0, 1, 1));
        // zero revolution wraps at the full position width
        add_cfg(CFG_STEPS_PER_REV, 0);
        add_beat(REQ_REL,    16'hFFFE, 16'h0000, 1, mk_res(4'b1001, 0, -2, 0, 0));
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 1, mk_res(4'b0001, 65535, -1, 0, 1));
        add_beat(REQ_ABS,    16'h0000, 16'd0,    1, mk_res(4'b0001, 65535, -65535, 0, 0));
        // largest revolution and delay
        add_cfg(CFG_STEPS_PER_REV, 65535);
        add_cfg(CFG_STEP_DELAY, 20'hFFFFF);
        add_beat(REQ_TICK,   16'h0000, 16'h0000, 0, '0);
        add_beat(REQ_ABS,    16'h0000, 16'hFFFE, 0, '0);

        // hold reset, then release it
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed rows
        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.is_cfg) write_reg(row.cfg_reg, row.cfg_val);
            else send_beat(row.kind, row.move, row.target, row.known, row.want);
        end

        // random phases: revolution, delay, sender idle %, receiver stall %, beats
        run_phase(4096,  0,        0,  0,  180);
        run_phase(1,     1,        56, 0,  160);
        run_phase(0,     2,        0,  56, 160);
        run_phase(65535, 0,        27, 27, 160);
        run_phase(7,     3,        0,  0,  160);
        run_phase(12345, 20'hFFFFF, 56, 0, 60);
        run_phase(48,    1,        0,  56, 160);

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
